// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker module of the unique-base finder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold in the same cycle as its trigger.
`define ABF_ASSERT_SAME(label, trig, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (prop)) \
        else $error(msg);

// Property that must hold in the cycle after its trigger.
`define ABF_ASSERT_NEXT(label, trig, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
        else $error(msg);

`endif

// ===== sv/abf_pkg.sv =====
// Package with shared constants, types and helpers of the unique-base finder.
`timescale 1ns / 1ps

package abf_pkg;

    localparam int MAX_LANES   = 8;
    localparam int LANE_W      = $clog2(MAX_LANES);
    localparam int CHAR_W      = 8;
    localparam int CFG_W       = 4;
    localparam int POS_W       = 32;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_W-1:0]  ACTIVE_RESET = CFG_W'(2);
    localparam logic [POS_W-1:0]  COUNT_MAX    = '1;
    localparam logic [CHAR_W-1:0] GAP_CHAR     = 8'h2D;

    // One column that produced at least one unique base.
    typedef struct packed {
        logic [MAX_LANES-1:0]            mask;
        logic [MAX_LANES-1:0][POS_W-1:0] lane_pos;
        logic [POS_W-1:0]                master_pos;
    } entry_t;

    // Write side of the column queue.
    typedef struct packed {
        logic   valid;
        entry_t entry;
    } push_t;

    // Read side of the column queue.
    typedef struct packed {
        logic   valid;
        entry_t entry;
    } head_t;

    // Gap and ambiguity codes stop a column from giving results.
    function automatic logic is_blocker(input logic [CHAR_W-1:0] c);
        logic hit;
        hit = c inside {"Y", "R", "W", "S", "K", "M", "D", "V", "H", "B", "N", GAP_CHAR};
        return hit;
    endfunction

endpackage

// ===== sv/abf_front.sv =====
// Front end: configuration, column and gap counters, and column classification.
`timescale 1ns / 1ps

module abf_front
    import abf_pkg::*;
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [CFG_W-1:0]                 cfg_wr_data,
    input  logic                             in_valid,
    input  logic [MAX_LANES-1:0][CHAR_W-1:0] chars,
    input  logic                             q_full,
    output push_t                            push
);

    logic [CFG_W-1:0]  active_reg;
    logic [POS_W-1:0]  column_reg;
    logic [POS_W-1:0]  column_next;
    logic [POS_W-1:0]  gap_reg  [MAX_LANES];
    logic [POS_W-1:0]  gap_next [MAX_LANES];
    logic [MAX_LANES-1:0] lane_act;
    logic [MAX_LANES-1:0] uniq;
    logic                 blocked;
    logic                 accept;

    // Ungapped coordinate; a gap count at or past the column reads as one.
    function automatic logic [POS_W-1:0] pos_of(input logic [POS_W-1:0] col,
                                                 input logic [POS_W-1:0] gaps);
        logic [POS_W-1:0] res;
        if (gaps >= col)
            res = POS_W'(1);
        else
            res = col - gaps;
        return res;
    endfunction

    assign accept = in_valid && !q_full;

    // Classify the column and work out the counter updates.
    always_comb
    begin
        blocked = 1'b0;
        for (int i = 0; i < MAX_LANES; i++)
        begin
            lane_act[i] = active_reg > CFG_W'(i);
            gap_next[i] = gap_reg[i];
            if (lane_act[i] && is_blocker(chars[i]))
                blocked = 1'b1;
            if (accept && lane_act[i] && chars[i] == GAP_CHAR && gap_reg[i] != COUNT_MAX)
                gap_next[i] = gap_reg[i] + POS_W'(1);
        end
        for (int i = 0; i < MAX_LANES; i++)
        begin
            uniq[i] = lane_act[i];
            for (int j = 0; j < MAX_LANES; j++)
            begin
                if (j != i && lane_act[j] && chars[j] == chars[i])
                    uniq[i] = 1'b0;
            end
        end
        column_next = column_reg;
        if (accept && column_reg != COUNT_MAX)
            column_next = column_reg + POS_W'(1);
    end

    // Build the queue beat; gap counts cannot move in a column that is not blocked.
    always_comb
    begin
        push.valid = accept && !blocked && (uniq != '0);
        push.entry.mask = uniq;
        for (int i = 0; i < MAX_LANES; i++)
            push.entry.lane_pos[i] = pos_of(column_reg, gap_reg[i]);
        push.entry.master_pos = pos_of(column_reg, gap_reg[0]);
    end

    // Configuration register and counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= ACTIVE_RESET;
            column_reg <= POS_W'(1);
            for (int i = 0; i < MAX_LANES; i++)
                gap_reg[i] <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                active_reg <= cfg_wr_data;
            column_reg <= column_next;
            for (int i = 0; i < MAX_LANES; i++)
                gap_reg[i] <= gap_next[i];
        end
    end

endmodule

// ===== sv/abf_queue.sv =====
// Short queue of classified columns between the front and back ends.
`timescale 1ns / 1ps

module abf_queue
    import abf_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  push_t push,
    input  logic  pop,
    output logic  full,
    output head_t head
);

    entry_t            mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg;
    logic [QCNT_W-1:0] cnt_next;

    assign full       = cnt_reg == QCNT_W'(QUEUE_DEPTH);
    assign head.valid = cnt_reg != '0;
    assign head.entry = mem_reg[rd_ptr_reg];

    // Occupancy follows pushes and pops.
    always_comb
    begin
        cnt_next = cnt_reg;
        if (push.valid && !pop)
            cnt_next = cnt_reg + QCNT_W'(1);
        else if (!push.valid && pop)
            cnt_next = cnt_reg - QCNT_W'(1);
    end

    // Pointers and count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push.valid)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            cnt_reg <= cnt_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push.valid)
            mem_reg[wr_ptr_reg] <= push.entry;
    end

endmodule

// ===== sv/abf_back.sv =====
// Back end: walks the unique lanes of the head column and registers one result per beat.
`timescale 1ns / 1ps

module abf_back
    import abf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  head_t             head,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [LANE_W-1:0] lane_index,
    output logic [POS_W-1:0]  lane_position,
    output logic [POS_W-1:0]  master_position,
    output logic              last_of_column
);

    logic [MAX_LANES-1:0] served_reg;
    logic [MAX_LANES-1:0] remain;
    logic [MAX_LANES-1:0] pick;
    logic [LANE_W-1:0]    pick_idx;
    logic                 pick_last;
    logic                 emit;
    logic                 out_valid_reg;
    logic [LANE_W-1:0]    lane_index_reg;
    logic [POS_W-1:0]     lane_position_reg;
    logic [POS_W-1:0]     master_position_reg;
    logic                 last_reg;

    // Lowest lane of the head column not yet sent.
    always_comb
    begin
        remain   = head.entry.mask & ~served_reg;
        pick     = remain & (~remain + MAX_LANES'(1));
        pick_idx = '0;
        for (int i = 0; i < MAX_LANES; i++)
        begin
            if (pick[i])
                pick_idx = LANE_W'(i);
        end
        pick_last = (remain & ~pick) == '0;
        emit      = head.valid && (!out_valid_reg || !out_stall);
        pop       = emit && pick_last;
    end

    // Lane walk and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            served_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (emit)
            begin
                if (pick_last)
                    served_reg <= '0;
                else
                    served_reg <= served_reg | pick;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            lane_index_reg      <= pick_idx;
            lane_position_reg   <= head.entry.lane_pos[pick_idx];
            master_position_reg <= head.entry.master_pos;
            last_reg            <= pick_last;
        end
    end

    assign out_valid       = out_valid_reg;
    assign lane_index      = lane_index_reg;
    assign lane_position   = lane_position_reg;
    assign master_position = master_position_reg;
    assign last_of_column  = last_reg;

endmodule

// ===== sv/alignment_unique_base_finder.sv =====
// Top level of the unique-base finder: front end, column queue and back end.
//
//   channel  direction  handshake            beat
//   cfg      in         cfg_wr_en            cfg_wr_data (active sequence count)
//   in       in         in_valid / in_stall  char_lane0 .. char_lane7
//   out      out        out_valid / out_stall lane_index, lane_position,
//                                            master_position, last_of_column
//
// The front end takes one column per cycle unless stalled and classifies it in that same cycle.
// The back end sends one result per cycle while out_stall is low, one per unique base of a column.
// An accepted column is written into the column queue, and the back end then registers its results.
// A four-entry column queue parts the two; in_stall is high only while it is full.
// Reset is asynchronous and active low; the active count returns to two.
`timescale 1ns / 1ps

module alignment_unique_base_finder
    import abf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [CFG_W-1:0]  cfg_wr_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [CHAR_W-1:0] char_lane0,
    input  logic [CHAR_W-1:0] char_lane1,
    input  logic [CHAR_W-1:0] char_lane2,
    input  logic [CHAR_W-1:0] char_lane3,
    input  logic [CHAR_W-1:0] char_lane4,
    input  logic [CHAR_W-1:0] char_lane5,
    input  logic [CHAR_W-1:0] char_lane6,
    input  logic [CHAR_W-1:0] char_lane7,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [LANE_W-1:0] lane_index,
    output logic [POS_W-1:0]  lane_position,
    output logic [POS_W-1:0]  master_position,
    output logic              last_of_column
);

    logic [MAX_LANES-1:0][CHAR_W-1:0] chars;
    push_t                            push;
    head_t                            head;
    logic                             q_full;
    logic                             pop;

    assign chars = {char_lane7, char_lane6, char_lane5, char_lane4,
                    char_lane3, char_lane2, char_lane1, char_lane0};
    assign in_stall = q_full;

    abf_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .chars       (chars),
        .q_full      (q_full),
        .push        (push)
    );

    abf_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .full  (q_full),
        .head  (head)
    );

    abf_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .head            (head),
        .pop             (pop),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .lane_index      (lane_index),
        .lane_position   (lane_position),
        .master_position (master_position),
        .last_of_column  (last_of_column)
    );

endmodule

// ===== sv/abf_checker.sv =====
// Port-level checker for the unique-base finder and its bind to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module abf_checker
    import abf_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_stall,
    input logic [LANE_W-1:0] lane_index,
    input logic [POS_W-1:0]  lane_position,
    input logic [POS_W-1:0]  master_position,
    input logic              last_of_column
);

    // A stalled result beat stays valid and keeps its lane position.
    `ABF_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(lane_position), "stalled result beat changed")

    // The master lane reports its own coordinate.
    `ABF_ASSERT_SAME(a_master_self, out_valid && lane_index == '0, lane_position == master_position, "master lane position mismatch")

    // Results of one column follow back to back with the same master coordinate.
    `ABF_ASSERT_NEXT(a_column_burst, out_valid && !out_stall && !last_of_column, out_valid && $stable(master_position), "column results not contiguous")

    // Within a column the lanes rise.
    `ABF_ASSERT_NEXT(a_lane_order, out_valid && !out_stall && !last_of_column, lane_index > $past(lane_index), "lane order broken within column")

endmodule

bind alignment_unique_base_finder abf_checker u_abf_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .lane_index      (lane_index),
    .lane_position   (lane_position),
    .master_position (master_position),
    .last_of_column  (last_of_column)
);

// ===== test/tb_alignment_unique_base_finder.sv =====
// Self-checking testbench for the alignment unique-base finder.
`timescale 1ns / 1ps

module tb_alignment_unique_base_finder;
    import abf_pkg::*;

    localparam string BASES           = "ACGT";
    localparam string AMBIGUITY_CODES = "YRWSKMDVHBN";
    localparam int    DRAIN_LIMIT     = 5000;
    localparam int    SETTLE_CYCLES   = 8;
    localparam int    RANDOM_PHASES   = 5;
    localparam int    PHASE_COLUMNS   = 20;
    localparam int    PRINT_LIMIT     = 40;

    typedef logic [MAX_LANES-1:0][CHAR_W-1:0] column_t;

    // One expected unique base, as it should leave the output channel.
    typedef struct {
        logic [LANE_W-1:0] lane;
        logic [POS_W-1:0]  lane_pos;
        logic [POS_W-1:0]  master_pos;
        logic              last;
    } unique_base_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_wr_en;
    logic [CFG_W-1:0]  cfg_wr_data;
    logic              in_valid;
    logic              in_stall;
    column_t           lane_chars;
    logic              out_valid;
    logic              out_stall;
    logic [LANE_W-1:0] lane_index;
    logic [POS_W-1:0]  lane_position;
    logic [POS_W-1:0]  master_position;
    logic              last_of_column;

    // Predictor state: setting, column number and per-lane gap counts.
    logic [CFG_W-1:0]  active_setting;
    logic [POS_W-1:0]  col_number;
    logic [POS_W-1:0]  lane_gaps [MAX_LANES];
    unique_base_t      pending_bases [$];

    bit quiet;
    int error_count;
    int columns_sent;
    int bases_checked;

    alignment_unique_base_finder u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .char_lane0      (lane_chars[0]),
        .char_lane1      (lane_chars[1]),
        .char_lane2      (lane_chars[2]),
        .char_lane3      (lane_chars[3]),
        .char_lane4      (lane_chars[4]),
        .char_lane5      (lane_chars[5]),
        .char_lane6      (lane_chars[6]),
        .char_lane7      (lane_chars[7]),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .lane_index      (lane_index),
        .lane_position   (lane_position),
        .master_position (master_position),
        .last_of_column  (last_of_column)
    );

    // Free-running clock with an 8 ns period.
    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Prints one line per problem, up to a cap, and counts every one.
    task automatic report_mismatch(input string what, input logic [POS_W-1:0] want,
                                   input logic [POS_W-1:0] got);
        if (error_count < PRINT_LIMIT)
            $display("ERROR at %0t ns: %s expected %0d got %0d", $time, what, want, got);
        error_count++;
    endtask

    function automatic logic [POS_W-1:0] sat_increment(input logic [POS_W-1:0] v);
        return (v == COUNT_MAX) ? v : v + POS_W'(1);
    endfunction

    // Ungapped coordinate; it bottoms out at 1 once the gaps catch up with the column.
    function automatic logic [POS_W-1:0] ungapped_position(input logic [POS_W-1:0] gaps);
        return (gaps >= col_number) ? POS_W'(1) : col_number - gaps;
    endfunction

    function automatic bit is_blocking_char(input logic [CHAR_W-1:0] c);
        if (c == GAP_CHAR)
            return 1'b1;
        for (int k = 0; k < AMBIGUITY_CODES.len(); k++)
            if (c == AMBIGUITY_CODES[k])
                return 1'b1;
        return 1'b0;
    endfunction

    // Builds a column from text; lanes past the text hold gaps.
    function automatic column_t make_column(input string s);
        column_t col;
        for (int i = 0; i < MAX_LANES; i++)
            col[i] = (i < s.len()) ? s[i] : GAP_CHAR;
        return col;
    endfunction

    // Mostly clean bases for deep coverage, with gaps, ambiguity codes and raw bytes mixed in.
    function automatic column_t random_column(input bit clean);
        column_t col;
        int      r;
        for (int i = 0; i < MAX_LANES; i++)
        begin
            r = $urandom_range(0, 99);
            if (clean)
            begin
                if (r < 75)
                    col[i] = BASES[$urandom_range(0, 3)];
                else if (r < 88)
                    col[i] = BASES[$urandom_range(0, 3)] | 8'h20;
                else
                    col[i] = CHAR_W'($urandom_range(0, 255));
            end
            else
            begin
                if (r < 50)
                    col[i] = BASES[$urandom_range(0, 3)];
                else if (r < 70)
                    col[i] = GAP_CHAR;
                else if (r < 85)
                    col[i] = AMBIGUITY_CODES[$urandom_range(0, AMBIGUITY_CODES.len() - 1)];
                else
                    col[i] = CHAR_W'($urandom_range(0, 255));
            end
        end
        return col;
    endfunction

    // Updates the predictor for one accepted column and queues the unique bases it yields.
    task automatic predict_unique_bases(input column_t col);
        int               lanes;
        int               same;
        bit               blocked;
        logic [POS_W-1:0] master;
        unique_base_t     found [$];
        unique_base_t     base;
        lanes   = (active_setting > MAX_LANES) ? MAX_LANES : int'(active_setting);
        blocked = 1'b0;
        for (int i = 0; i < lanes; i++)
        begin
            if (col[i] == GAP_CHAR)
                lane_gaps[i] = sat_increment(lane_gaps[i]);
            if (is_blocking_char(col[i]))
                blocked = 1'b1;
        end
        if (!blocked)
        begin
            master = ungapped_position(lane_gaps[0]);
            for (int i = 0; i < lanes; i++)
            begin
                same = 0;
                for (int j = 0; j < lanes; j++)
                    if (col[j] == col[i])
                        same++;
                if (same == 1)
                begin
                    base.lane       = LANE_W'(i);
                    base.lane_pos   = ungapped_position(lane_gaps[i]);
                    base.master_pos = master;
                    base.last       = 1'b0;
                    found.push_back(base);
                end
            end
            if (found.size() > 0)
                found[found.size() - 1].last = 1'b1;
            foreach (found[k])
                pending_bases.push_back(found[k]);
        end
        col_number = sat_increment(col_number);
    endtask

    // Presents one column beat, optionally after an idle burst, and waits for acceptance.
    task automatic send_column(input column_t col);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 12);
            @(negedge clk);
            in_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid   = 1'b1;
        lane_chars = col;
        do
            @(posedge clk);
        while (in_stall);
        predict_unique_bases(col);
        columns_sent++;
    endtask

    // Drops valid and waits, with a bound, until every expected base has arrived.
    task automatic wait_drained;
        int waited;
        waited = 0;
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_bases.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (pending_bases.size() != 0)
        begin
            report_mismatch("outstanding results", POS_W'(0), POS_W'(pending_bases.size()));
            pending_bases.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes the active sequence count while the block is idle.
    task automatic set_active_sequences(input logic [CFG_W-1:0] value);
        wait_drained();
        @(negedge clk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = value;
        @(posedge clk);
        active_setting = value;
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    // Reset default of two lanes: gaps and codes in unused lanes must not matter.
    task automatic test_default_two_lanes;
        send_column(make_column("AC"));
        send_column(make_column("GG"));
        send_column(make_column("T-"));
        send_column(make_column("NA"));
        send_column(make_column("nA"));
        send_column(make_column("-C"));
        send_column(make_column("AC"));
    endtask

    // All eight lanes, including the busiest column and the extreme byte values.
    task automatic test_full_width;
        column_t col;
        set_active_sequences(CFG_W'(MAX_LANES));
        send_column(make_column("ACGTacgt"));
        col    = make_column("xxxACGTa");
        col[0] = 8'h00;
        col[1] = 8'hFF;
        col[2] = 8'h00;
        send_column(col);
        send_column({MAX_LANES{8'hFF}});
        send_column(make_column("AAAAAAAC"));
    endtask

    // Each gap or ambiguity code on its own blocks the whole column.
    task automatic test_blocking_codes;
        column_t col;
        string   codes;
        codes = {AMBIGUITY_CODES, "-"};
        for (int k = 0; k < codes.len(); k++)
        begin
            col                = make_column("ACGTacgt");
            col[k % MAX_LANES] = codes[k];
            send_column(col);
        end
    endtask

    // No lanes, a count past the lane limit, and a single lane.
    task automatic test_lane_count_limits;
        set_active_sequences('0);
        send_column(make_column("ACGTacgt"));
        send_column(make_column("--------"));
        set_active_sequences('1);
        send_column(make_column("ACGTacgt"));
        set_active_sequences(CFG_W'(1));
        send_column(make_column("A"));
        send_column(make_column("-"));
        send_column(make_column("C"));
    endtask

    // Random columns over several lane counts; the last phase runs without idling.
    task automatic test_random_columns;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            set_active_sequences(CFG_W'($urandom_range(1, 15)));
            if (phase == RANDOM_PHASES - 1)
                quiet = 1'b1;
            for (int k = 0; k < PHASE_COLUMNS; k++)
                send_column(random_column($urandom_range(0, 3) != 0));
        end
    endtask

    // Output side stalls in random bursts, with free-running stretches between.
    initial
    begin : output_stall_gen
        int  burst;
        bit  stall_now;
        out_stall = 1'b0;
        forever
        begin
            burst     = $urandom_range(1, 12);
            stall_now = ($urandom_range(0, 2) == 0);
            repeat (burst)
            begin
                @(negedge clk);
                out_stall = stall_now && !quiet;
            end
        end
    end

    // Each accepted result beat is matched against the oldest expected base.
    always @(posedge clk)
    begin
        unique_base_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_bases.size() == 0)
                report_mismatch("unexpected result on lane", POS_W'(0), POS_W'(lane_index));
            else
            begin
                want = pending_bases.pop_front();
                if (lane_index !== want.lane)
                    report_mismatch("lane_index", POS_W'(want.lane), POS_W'(lane_index));
                if (lane_position !== want.lane_pos)
                    report_mismatch("lane_position", want.lane_pos, lane_position);
                if (master_position !== want.master_pos)
                    report_mismatch("master_position", want.master_pos, master_position);
                if (last_of_column !== want.last)
                    report_mismatch("last_of_column", POS_W'(want.last),
                                    POS_W'(last_of_column));
                bases_checked++;
            end
        end
    end

    // Main sequence: reset, directed tests, random columns, then the verdict.
    initial
    begin
        rst_n          = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        in_valid       = 1'b0;
        lane_chars     = '0;
        quiet          = 1'b0;
        error_count    = 0;
        columns_sent   = 0;
        bases_checked  = 0;
        active_setting = ACTIVE_RESET;
        col_number     = POS_W'(1);
        foreach (lane_gaps[i])
            lane_gaps[i] = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_default_two_lanes();
        test_full_width();
        test_blocking_codes();
        test_lane_count_limits();
        test_random_columns();
        wait_drained();

        $display("summary: %0d columns sent, %0d unique-base results checked, %0d errors",
                 columns_sent, bases_checked, error_count);
        $display("summary: lane counts 0, 1, 2, 8 and 15 plus random counts were exercised");
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
